/* src/msbfs_pkg.sv */
// ----------------------------------------------------------------------------
// msbfs_pkg
// Shared types and constants for the MSB-first bit-field store.
// ----------------------------------------------------------------------------
package msbfs_pkg;

  // default store depth in 32-bit words
  localparam int STORE_WORDS_DEF = 256;
  localparam int WORD_W          = 32;
  localparam int OFFSET_W        = 13;
  localparam int FWIDTH_W        = 6;
  // word index taken from an offset, plus one for the second word
  localparam int WIDX_W          = OFFSET_W - 5 + 1;

  // memory port operation for one cycle
  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_RD0,
    MEM_RD1,
    MEM_WR0,
    MEM_WR1,
    MEM_CLR
  } mem_op_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load_in;
    mem_op_t mem_op;
    logic    merge;
    logic    load_out;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic is_write;
  } dp_stat_t;

endpackage

/* src/msb_first_bitfield_store.sv */
// ----------------------------------------------------------------------------
// msb_first_bitfield_store
// Bit-addressed flag store of 32-bit words, bit 0 at the MSB of word 0.
// Reads or writes a field of 0 to 32 bits at any bit offset.
// ----------------------------------------------------------------------------
//  channel  signals                                      direction
//  in       in_valid/in_ready, op, bit_offset,           into block
//           field_width, write_value
//  out      out_valid/out_ready, read_value,             out of block
//           out_of_range
//
//  a read steps through two word reads, merge and post to result valid; a
//  write adds two word writes after merge, as the single memory port serves
//  one word per step. the next item can be taken in the cycle after the
//  result is loaded into the output register. after reset the store is
//  cleared one word a cycle, all STORE_WORDS words, with in_ready low
//  a stalled output holds its result; a new item may be taken meanwhile
// ----------------------------------------------------------------------------
module msb_first_bitfield_store import msbfs_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [OFFSET_W-1:0] bit_offset,
  input  logic [FWIDTH_W-1:0] field_width,
  input  logic [WORD_W-1:0]   write_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WORD_W-1:0]   read_value,
  output logic                out_of_range
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  msbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memory and field logic
  msbfs_dpath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .bit_offset   (bit_offset),
    .field_width  (field_width),
    .write_value  (write_value),
    .read_value   (read_value),
    .out_of_range (out_of_range)
  );

endmodule

/* src/msbfs_dpath.sv */
// ----------------------------------------------------------------------------
// msbfs_dpath
// Word memory, clear sweep counter, field extract and merge logic, and the
// result register.
// ----------------------------------------------------------------------------
module msbfs_dpath import msbfs_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                op,
  input  logic [OFFSET_W-1:0] bit_offset,
  input  logic [FWIDTH_W-1:0] field_width,
  input  logic [WORD_W-1:0]   write_value,
  output logic [WORD_W-1:0]   read_value,
  output logic                out_of_range
);

  localparam int AW       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int XW       = (AW > WIDX_W) ? AW : WIDX_W;
  localparam int CAP_BITS = STORE_WORDS * WORD_W;

  logic [WORD_W-1:0]   mem [STORE_WORDS];
  logic [WORD_W-1:0]   rdata;

  // latched item
  logic                op_r;
  logic [OFFSET_W-1:0] base_r;
  logic [FWIDTH_W-1:0] width_r;
  logic [WORD_W-1:0]   wval_r;

  logic [WORD_W-1:0]   word0;
  logic [WORD_W-1:0]   nw0;
  logic [WORD_W-1:0]   nw1;
  logic                we0;
  logic                we1;
  logic [WORD_W-1:0]   rd_r;
  logic                oor_r;
  logic [AW-1:0]       clr_cnt;

  logic [WIDX_W-1:0]   widx0;
  logic [WIDX_W-1:0]   widx1;
  logic                in0;
  logic                in1;
  logic [AW-1:0]       addr0;
  logic [AW-1:0]       addr1;
  logic [4:0]          shamt;
  logic [FWIDTH_W-1:0] inv_w;

  logic [WORD_W-1:0]   word1;
  logic [2*WORD_W-1:0] win;
  logic [2*WORD_W-1:0] win_sh;
  logic [WORD_W-1:0]   rd_val;
  logic [WORD_W-1:0]   lj_mask;
  logic [WORD_W-1:0]   lj_data;
  logic [2*WORD_W-1:0] m64;
  logic [2*WORD_W-1:0] d64;
  logic [2*WORD_W-1:0] new_win;
  logic [OFFSET_W:0]   last_bit;
  logic                oor;

  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_addr;
  logic [WORD_W-1:0]   mem_wdata;

  // word indexes and range of the two words the field may touch
  assign widx0 = {1'b0, base_r[OFFSET_W-1:5]};
  assign widx1 = widx0 + WIDX_W'(1);
  assign in0   = 32'(widx0) < 32'(STORE_WORDS);
  assign in1   = 32'(widx1) < 32'(STORE_WORDS);
  assign addr0 = XW'(widx0) >> 0 == '0 ? '0 : AW'(XW'(widx0));
  assign addr1 = AW'(XW'(widx1));
  assign shamt = base_r[4:0];
  assign inv_w = FWIDTH_W'(WORD_W) - width_r;

  // extract and merge over the two-word window
  always_comb begin
    word1    = in1 ? rdata : '0;
    win      = {word0, word1};
    win_sh   = win << shamt;
    rd_val   = (width_r == '0) ? '0 : (win_sh[2*WORD_W-1:WORD_W] >> inv_w);
    lj_mask  = ~({WORD_W{1'b1}} >> width_r);
    lj_data  = (wval_r << inv_w) & lj_mask;
    m64      = {lj_mask, {WORD_W{1'b0}}} >> shamt;
    d64      = {lj_data, {WORD_W{1'b0}}} >> shamt;
    new_win  = (win & ~m64) | (d64 & m64);
    last_bit = {1'b0, base_r} + (OFFSET_W+1)'(width_r) - (OFFSET_W+1)'(1);
    oor      = (width_r != '0) && (32'(last_bit) >= 32'(CAP_BITS));
  end

  // memory port select
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr0;
    mem_wdata = '0;
    case (cmd.mem_op)
      MEM_RD0: begin
        mem_re = 1'b1;
      end
      MEM_RD1: begin
        mem_re   = 1'b1;
        mem_addr = addr1;
      end
      MEM_WR0: begin
        mem_we    = we0;
        mem_wdata = nw0;
      end
      MEM_WR1: begin
        mem_we    = we1;
        mem_addr  = addr1;
        mem_wdata = nw1;
      end
      MEM_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // single-port word memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.mem_op == MEM_CLR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign stat.clr_last = (clr_cnt == AW'(STORE_WORDS - 1));
  assign stat.is_write = op_r;

  // item, window and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= op;
      base_r  <= bit_offset;
      width_r <= (field_width > FWIDTH_W'(WORD_W)) ? FWIDTH_W'(WORD_W) : field_width;
      wval_r  <= write_value;
    end
    if (cmd.mem_op == MEM_RD1) begin
      word0 <= in0 ? rdata : '0;
    end
    if (cmd.merge) begin
      nw0   <= new_win[2*WORD_W-1:WORD_W];
      nw1   <= new_win[WORD_W-1:0];
      we0   <= op_r && in0 && (m64[2*WORD_W-1:WORD_W] != '0);
      we1   <= op_r && in1 && (m64[WORD_W-1:0] != '0);
      rd_r  <= op_r ? '0 : rd_val;
      oor_r <= oor;
    end
    if (cmd.load_out) begin
      read_value   <= rd_r;
      out_of_range <= oor_r;
    end
  end

endmodule

/* src/msbfs_ctrl.sv */
// ----------------------------------------------------------------------------
// msbfs_ctrl
// Sequencer for the clear sweep and the read / merge / write steps of one
// item, plus the output valid flag.
// ----------------------------------------------------------------------------
module msbfs_ctrl import msbfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD0,
    S_RD1,
    S_MERGE,
    S_WR0,
    S_WR1,
    S_POST
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // command decode and next state
  always_comb begin
    cmd        = '{load_in: 1'b0, mem_op: MEM_IDLE, merge: 1'b0, load_out: 1'b0};
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.mem_op = MEM_CLR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_RD0;
        end
      end
      S_RD0: begin
        cmd.mem_op = MEM_RD0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.mem_op = MEM_RD1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = stat.is_write ? S_WR0 : S_POST;
      end
      S_WR0: begin
        cmd.mem_op = MEM_WR0;
        state_next = S_WR1;
      end
      S_WR1: begin
        cmd.mem_op = MEM_WR1;
        state_next = S_POST;
      end
      S_POST: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a new result appears only out of the post step
  a_rise_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_POST)
    else $error("result valid without post step");

  // an accepted transfer starts the first word read
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_RD0)
    else $error("accepted item did not start reading");

  // reads skip the write-back steps
  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE && !stat.is_write) |=> state == S_POST)
    else $error("read item entered write-back");

  // a result held by a stalled output is not overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.load_out)
    else $error("result overwritten while stalled");

endmodule
